// ----- hw/rtl/msd_pkg.sv -----
package msd_pkg;

	localparam int unsigned MaxElements = 6;
	localparam int unsigned EndDashes   = 6;
	localparam int unsigned RomSize     = 37;

	localparam int unsigned CountW = $clog2(MaxElements + 1);

	typedef enum logic [7:0] {
		KEY_DOT  = 8'd1,
		KEY_DASH = 8'd2,
		KEY_GAP  = 8'd4
	} key_code_t;

	typedef struct packed {
		logic [CountW-1:0]      len;
		logic [MaxElements-1:0] bits;
		logic [6:0]             ch;
	} code_entry_t;

	typedef struct packed {
		logic       hit;
		logic [6:0] ch;
	} lookup_t;

	typedef struct packed {
		logic       valid;
		logic [6:0] ascii_char;
		logic       message_end;
	} result_t;

	// bit k of bits is element k, 1 = dash
	localparam code_entry_t CODE_ROM [RomSize] = '{
		'{3'd2, 6'd2,  7'h41}, '{3'd4, 6'd1,  7'h42}, '{3'd4, 6'd5,  7'h43},
		'{3'd3, 6'd1,  7'h44}, '{3'd1, 6'd0,  7'h45}, '{3'd4, 6'd4,  7'h46},
		'{3'd3, 6'd3,  7'h47}, '{3'd4, 6'd0,  7'h48}, '{3'd2, 6'd0,  7'h49},
		'{3'd4, 6'd14, 7'h4A}, '{3'd3, 6'd5,  7'h4B}, '{3'd4, 6'd2,  7'h4C},
		'{3'd2, 6'd3,  7'h4D}, '{3'd2, 6'd1,  7'h4E}, '{3'd3, 6'd7,  7'h4F},
		'{3'd4, 6'd6,  7'h50}, '{3'd4, 6'd11, 7'h51}, '{3'd3, 6'd2,  7'h52},
		'{3'd3, 6'd0,  7'h53}, '{3'd1, 6'd1,  7'h54}, '{3'd3, 6'd4,  7'h55},
		'{3'd4, 6'd8,  7'h56}, '{3'd3, 6'd6,  7'h57}, '{3'd4, 6'd9,  7'h58},
		'{3'd4, 6'd13, 7'h59}, '{3'd4, 6'd3,  7'h5A}, '{3'd6, 6'd0,  7'h20},
		'{3'd5, 6'd31, 7'h30}, '{3'd5, 6'd30, 7'h31}, '{3'd5, 6'd28, 7'h32},
		'{3'd5, 6'd24, 7'h33}, '{3'd5, 6'd16, 7'h34}, '{3'd5, 6'd0,  7'h35},
		'{3'd5, 6'd1,  7'h36}, '{3'd5, 6'd3,  7'h37}, '{3'd5, 6'd7,  7'h38},
		'{3'd5, 6'd15, 7'h39}
	};

endpackage

// ----- hw/rtl/morse_symbol_decoder.sv -----
// Each accepted beat goes to the input register; its decoded result is then registered.
// One key code per cycle unless in_stall; an input register feeds the decode logic and a
// result register holds the character, so one more beat still enters behind a waiting result.
// Input stalls only while the input register is full and the result register is held.
// Reset (arst_n low) clears the collected pattern, dash run, end flag and both valid bits.
module morse_symbol_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] key_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] ascii_char,
	output logic       message_end
);

	logic             valid_s1;
	logic [7:0]       key_code_s1;
	logic             advance;
	logic             out_valid_q;
	logic [6:0]       ascii_char_q;
	logic             message_end_q;
	msd_pkg::result_t result;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			key_code_s1 <= key_code;
		end
	end

	msd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.key_code (key_code_s1),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result.valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			ascii_char_q  <= result.ascii_char;
			message_end_q <= result.message_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign ascii_char  = ascii_char_q;
	assign message_end = message_end_q;

endmodule

// ----- hw/rtl/msd_lookup.sv -----
module msd_lookup (
	input  logic [msd_pkg::CountW-1:0]      element_count,
	input  logic [msd_pkg::MaxElements-1:0] element_pattern,
	output msd_pkg::lookup_t                lookup
);

	// codes are unique, so a plain OR over the matching rows suffices
	always_comb begin
		lookup = '0;
		for (int i = 0; i < msd_pkg::RomSize; i++) begin
			if (msd_pkg::CODE_ROM[i].len == element_count &&
			    msd_pkg::CODE_ROM[i].bits == element_pattern) begin
				lookup.hit = 1'b1;
				lookup.ch  = lookup.ch | msd_pkg::CODE_ROM[i].ch;
			end
		end
	end

endmodule

// ----- hw/rtl/msd_core.sv -----
module msd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       key_code,
	output msd_pkg::result_t result
);

	logic [msd_pkg::MaxElements-1:0] element_pattern_q, element_pattern_d;
	logic [msd_pkg::CountW-1:0]      element_count_q, element_count_d;
	logic                            pattern_overflow_q, pattern_overflow_d;
	logic [msd_pkg::CountW-1:0]      dash_run_q, dash_run_d;
	logic                            finished_q, finished_d;
	logic [msd_pkg::CountW-1:0]      dash_run_inc;
	msd_pkg::lookup_t                lookup;

	msd_lookup u_lookup (
		.element_count   (element_count_q),
		.element_pattern (element_pattern_q),
		.lookup          (lookup)
	);

	assign dash_run_inc = dash_run_q + msd_pkg::CountW'(1);

	always_comb begin
		element_pattern_d  = element_pattern_q;
		element_count_d    = element_count_q;
		pattern_overflow_d = pattern_overflow_q;
		dash_run_d         = dash_run_q;
		finished_d         = finished_q;
		result             = '0;
		if (!finished_q) begin
			case (key_code)
				msd_pkg::KEY_DOT: begin
					dash_run_d = '0;
					if (element_count_q < msd_pkg::CountW'(msd_pkg::MaxElements)) begin
						element_count_d = element_count_q + msd_pkg::CountW'(1);
					end else begin
						pattern_overflow_d = 1'b1;
					end
				end
				msd_pkg::KEY_DASH: begin
					if (dash_run_inc >= msd_pkg::CountW'(msd_pkg::EndDashes)) begin
						// end of message: pending pattern dropped
						finished_d         = 1'b1;
						element_pattern_d  = '0;
						element_count_d    = '0;
						pattern_overflow_d = 1'b0;
						dash_run_d         = '0;
						result.valid       = 1'b1;
						result.message_end = 1'b1;
					end else begin
						dash_run_d = dash_run_inc;
						if (element_count_q < msd_pkg::CountW'(msd_pkg::MaxElements)) begin
							element_pattern_d[element_count_q] = 1'b1;
							element_count_d = element_count_q + msd_pkg::CountW'(1);
						end else begin
							pattern_overflow_d = 1'b1;
						end
					end
				end
				msd_pkg::KEY_GAP: begin
					dash_run_d         = '0;
					element_pattern_d  = '0;
					element_count_d    = '0;
					pattern_overflow_d = 1'b0;
					result.valid       = lookup.hit && !pattern_overflow_q;
					result.ascii_char  = lookup.ch;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_pattern_q  <= '0;
			element_count_q    <= '0;
			pattern_overflow_q <= 1'b0;
			dash_run_q         <= '0;
			finished_q         <= 1'b0;
		end else if (advance) begin
			element_pattern_q  <= element_pattern_d;
			element_count_q    <= element_count_d;
			pattern_overflow_q <= pattern_overflow_d;
			dash_run_q         <= dash_run_d;
			finished_q         <= finished_d;
		end
	end

	a_finished_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("finished cleared without reset");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		element_count_q <= msd_pkg::CountW'(msd_pkg::MaxElements))
		else $error("element count out of range");

	a_dash_run_range: assert property (@(posedge clk) disable iff (!arst_n)
		dash_run_q < msd_pkg::CountW'(msd_pkg::EndDashes))
		else $error("dash run reached end count without ending");

	a_pattern_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(element_pattern_q >> element_count_q) == '0)
		else $error("pattern bit set beyond element count");

	a_end_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		result.message_end |-> (result.ascii_char == '0 && result.valid))
		else $error("end marker carries a character");

endmodule

// ----- verif/tb_morse_symbol_decoder.sv -----
`timescale 1ns / 100ps

module tb_morse_symbol_decoder;

	localparam int RandomKeys = 950;
	localparam int TailKeys   = 100;
	localparam int CycleLimit = 200000;

	typedef struct {
		logic [6:0] ch;
		logic       fin;
	} decoded_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] key_code = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [6:0] ascii_char;
	logic       message_end;

	// Morse text for each character of char_set, same order
	string morse_tab [37] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--..",
		"-----", ".----", "..---", "...--", "....-",
		".....", "-....", "--...", "---..", "----.", "......"
	};
	string char_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 ";

	logic [7:0] key_q [$];
	decoded_t   decoded_q [$];

	// decoder state mirror
	logic [5:0] pat_bits = '0;
	logic [2:0] pat_len = '0;
	logic       pat_over = 1'b0;
	logic [2:0] dash_cnt = '0;
	logic       msg_done = 1'b0;

	int issued_cnt = 0;
	int accepted_cnt = 0;
	int char_cnt = 0;
	int end_cnt = 0;
	int err_cnt = 0;
	int cycle_cnt = 0;
	int gen_dash = 0;
	int elem_cnt = 0;
	logic quiet = 1'b0;
	logic send_mode = 1'b1;
	logic recv_mode = 1'b1;
	int send_gap = 0;
	int stall_left = 0;

	morse_symbol_decoder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.key_code   (key_code),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ascii_char (ascii_char),
		.message_end(message_end)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// returns {hit, char}
	function automatic logic [7:0] lookup_char(logic [2:0] len, logic [5:0] bits);
		string s;
		logic [5:0] b;
		byte c;
		for (int i = 0; i < 37; i++) begin
			s = morse_tab[i];
			b = '0;
			for (int k = 0; k < s.len(); k++)
				if (s[k] == "-")
					b[k] = 1'b1;
			if (s.len() == len && b == bits) begin
				c = char_set[i];
				return {1'b1, c[6:0]};
			end
		end
		return 8'h00;
	endfunction

	function automatic void clear_pattern();
		pat_bits = '0;
		pat_len = '0;
		pat_over = 1'b0;
	endfunction

	function automatic void add_element(logic is_dash);
		if (pat_len < msd_pkg::MaxElements) begin
			if (is_dash)
				pat_bits[pat_len] = 1'b1;
			pat_len = pat_len + 3'd1;
		end else begin
			pat_over = 1'b1;
		end
	endfunction

	function automatic void decode_key(logic [7:0] key);
		logic [7:0] hit_ch;
		if (msg_done)
			return;
		case (key)
			msd_pkg::KEY_DOT: begin
				dash_cnt = '0;
				add_element(1'b0);
			end
			msd_pkg::KEY_DASH: begin
				add_element(1'b1);
				if (dash_cnt < msd_pkg::EndDashes)
					dash_cnt = dash_cnt + 3'd1;
				if (dash_cnt >= msd_pkg::EndDashes) begin
					msg_done = 1'b1;
					clear_pattern();
					dash_cnt = '0;
					decoded_q.push_back('{7'd0, 1'b1});
				end
			end
			msd_pkg::KEY_GAP: begin
				dash_cnt = '0;
				hit_ch = (pat_len != 0 && !pat_over) ? lookup_char(pat_len, pat_bits) : 8'h00;
				clear_pattern();
				if (hit_ch[7])
					decoded_q.push_back('{hit_ch[6:0], 1'b0});
			end
			default: ;
		endcase
	endfunction

	// queues a key; a sixth dash in a row is turned into a dot so the message
	// only ends where the stimulus means it to
	task automatic push_key(logic [7:0] k);
		if (k == msd_pkg::KEY_DASH && gen_dash == msd_pkg::EndDashes - 1)
			k = msd_pkg::KEY_DOT;
		if (k == msd_pkg::KEY_DASH)
			gen_dash++;
		else if (k == msd_pkg::KEY_DOT || k == msd_pkg::KEY_GAP)
			gen_dash = 0;
		elem_cnt++;
		key_q.push_back(k);
	endtask

	task automatic push_pattern(int len);
		repeat (len)
			push_key($urandom_range(0, 1) ? msd_pkg::KEY_DASH : msd_pkg::KEY_DOT);
	endtask

	task automatic wait_drained();
		while (key_q.size() != 0 || issued_cnt != accepted_cnt || decoded_q.size() != 0)
			@(posedge clk);
	endtask

	// sender
	always @(negedge clk) begin
		logic       nxt_valid;
		logic [7:0] nxt_key;
		if (arst_n) begin
			if ($urandom_range(0, 199) == 0)
				send_mode = ~send_mode;
			if (issued_cnt == accepted_cnt) begin
				nxt_valid = 1'b0;
				nxt_key = key_code;
				if (send_gap > 0) begin
					send_gap--;
				end else if (send_mode && !quiet && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 15);
				end else if (key_q.size() != 0) begin
					nxt_key = key_q.pop_front();
					nxt_valid = 1'b1;
					issued_cnt++;
				end
				in_valid <= nxt_valid;
				key_code <= nxt_key;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 199) == 0)
				recv_mode = ~recv_mode;
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (recv_mode && !quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 15);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// result check and input beat capture
	always @(posedge clk) begin
		decoded_t e;
		cycle_cnt++;
		if (cycle_cnt > CycleLimit) begin
			$display("tb_morse_symbol_decoder: done, errors");
			$finish;
		end else if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected result: ascii_char %h message_end %b",
						ascii_char, message_end);
					err_cnt++;
				end else begin
					e = decoded_q.pop_front();
					if (ascii_char !== e.ch) begin
						$error("ascii_char: expected %h, actual %h", e.ch, ascii_char);
						err_cnt++;
					end
					if (message_end !== e.fin) begin
						$error("message_end: expected %b, actual %b", e.fin, message_end);
						err_cnt++;
					end
					if (e.fin)
						end_cnt++;
					else
						char_cnt++;
				end
			end
			if (in_valid && !in_stall) begin
				accepted_cnt++;
				decode_key(key_code);
			end
		end
	end

	initial begin
		string s;
		int kind;
		int idx;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: odd codes, E, 0 (five dashes), empty gap,
		// overlong with a dot breaking the dash run, unknown pattern
		push_key(8'hFF);
		push_key(8'h00);
		push_key(8'h80);
		push_key(8'h03);
		push_key(msd_pkg::KEY_DOT);
		push_key(msd_pkg::KEY_GAP);
		repeat (5) push_key(msd_pkg::KEY_DASH);
		push_key(msd_pkg::KEY_GAP);
		push_key(msd_pkg::KEY_GAP);
		repeat (3) push_key(msd_pkg::KEY_DASH);
		push_key(msd_pkg::KEY_DOT);
		repeat (3) push_key(msd_pkg::KEY_DASH);
		push_key(msd_pkg::KEY_GAP);
		push_key(msd_pkg::KEY_DOT);
		push_key(msd_pkg::KEY_DOT);
		push_key(msd_pkg::KEY_DASH);
		push_key(msd_pkg::KEY_DASH);
		push_key(msd_pkg::KEY_GAP);

		// hold off until the decoder has emptied
		wait_drained();
		repeat (3) @(posedge clk);

		elem_cnt = 0;
		while (elem_cnt < RandomKeys) begin
			while (key_q.size() > 32)
				@(posedge clk);
			if (elem_cnt >= RandomKeys - TailKeys)
				quiet = 1'b1;
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				idx = $urandom_range(0, 36);
				s = morse_tab[idx];
				for (int k = 0; k < s.len(); k++) begin
					if ($urandom_range(0, 9) == 0)
						push_key(8'($urandom));
					push_key(s[k] == "-" ? msd_pkg::KEY_DASH : msd_pkg::KEY_DOT);
				end
				push_key(msd_pkg::KEY_GAP);
			end else if (kind < 72) begin
				push_pattern($urandom_range(1, msd_pkg::MaxElements));
				push_key(msd_pkg::KEY_GAP);
			end else if (kind < 80) begin
				push_pattern($urandom_range(msd_pkg::MaxElements + 1, 10));
				push_key(msd_pkg::KEY_GAP);
			end else if (kind < 87) begin
				push_key(msd_pkg::KEY_GAP);
			end else if (kind < 95) begin
				repeat ($urandom_range(1, 3))
					push_key(8'($urandom));
			end else begin
				// broken letter, runs into the next one
				push_pattern($urandom_range(1, 4));
			end
		end

		// six dashes end the message; noise inside the run does not break it
		push_key(msd_pkg::KEY_GAP);
		repeat (3) key_q.push_back(msd_pkg::KEY_DASH);
		key_q.push_back(8'h06);
		repeat (3) key_q.push_back(msd_pkg::KEY_DASH);
		// ignored after the end marker
		key_q.push_back(msd_pkg::KEY_DOT);
		key_q.push_back(msd_pkg::KEY_GAP);
		key_q.push_back(msd_pkg::KEY_DASH);
		key_q.push_back(8'hFB);

		wait_drained();
		repeat (6) @(posedge clk);

		$display("covered %0d key beats: %0d characters and %0d end marker checked",
			accepted_cnt, char_cnt, end_cnt);
		$display("random letters, unknown, empty and overlong patterns, noise codes, stalls");
		if (err_cnt == 0)
			$display("tb_morse_symbol_decoder: done, clean");
		else
			$display("tb_morse_symbol_decoder: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/msd_pkg.sv
hw/rtl/msd_lookup.sv
hw/rtl/msd_core.sv
hw/rtl/morse_symbol_decoder.sv
verif/tb_morse_symbol_decoder.sv
